@@ rtl/scba_pkg.sv @@
// ----------------------------------------------------------------------------
// scba_pkg: shared types and constants of the size class block allocator
// Holds the request and response words, the command and status codes, and
// the fixed address geometry of the heap.
// ----------------------------------------------------------------------------
package scba_pkg;

  // Fixed geometry of the heap and of the word fields.
  localparam int HEAP_ADDR_BITS  = 20;
  localparam int SIZE_W          = 17;
  localparam int CHUNK_W         = 21;
  localparam int CLS_W           = 5;
  localparam int STATUS_W        = 3;
  localparam int AW              = HEAP_ADDR_BITS + 2;
  localparam int TAG_AW          = HEAP_ADDR_BITS - 4;
  localparam int TAG_DEPTH       = 1 << TAG_AW;
  localparam int HEADER_BYTES    = 16;
  localparam int HDR16           = ((HEADER_BYTES + 15) / 16) * 16;
  localparam int CLASS_EXP_LIMIT = 30;

  // Defaults of the top-level parameters.
  localparam int MAX_CLASS_DEF   = 16;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(4096);
  localparam logic [AW-1:0]      HEAP_END    = AW'(1) << HEAP_ADDR_BITS;

  // Commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOMEM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

  typedef struct packed {
    logic                      cmd;
    logic [SIZE_W-1:0]         req_size;
    logic [HEAP_ADDR_BITS-1:0] free_addr;
  } scba_req_t;

  typedef struct packed {
    logic [HEAP_ADDR_BITS-1:0] addr;
    logic [STATUS_W-1:0]       status;
  } scba_rsp_t;

endpackage

@@ rtl/scba_ram.sv @@
// ----------------------------------------------------------------------------
// scba_ram: simple dual-port synchronous memory
// One write port and one read port; the read data is registered, so it is
// valid in the cycle after the read enable.
// ----------------------------------------------------------------------------
module scba_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/size_class_block_allocator.sv @@
// ----------------------------------------------------------------------------
// size_class_block_allocator: segregated free-list allocator
// Rounds allocate sizes up to power-of-two classes, pops freed blocks from a
// per-class LIFO stack or carves new blocks from the current chunk, and
// pushes freed blocks back onto the stack of their recorded class.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Word
//   -------   ---------------------   -------------------------------------
//   request   req_valid / req_stall   req: cmd, req_size, free_addr
//   response  rsp_valid / rsp_stall   rsp: addr, status
//   config    cfg_we                  cfg_wdata: chunk_bytes
//
// A free passes through FREE and DONE on its way to the response register, an
// allocate carved from the chunk through CLASS, ALLOC and DONE, and an allocate
// served from a free stack through CLASS, ALLOC, POP and DONE. The path is set
// by the registered reads of the tag memory and of the stack memory, and by the
// class computation, which has a state of its own before the chunk arithmetic.
// The request side stays stalled until the finished word has entered the
// response register, so the block works on one request at a time, whether it
// is a free, a carved allocate or a stacked allocate.
// Reset is synchronous and clears the stack fill counts, the chunk pointers
// and the chunk size register; neither memory is cleared.
// A stalled response is held in the output register while the next request
// is already accepted and worked on; that request waits only at its end.
//
module size_class_block_allocator import scba_pkg::*; #(
  parameter int MAX_CLASS   = MAX_CLASS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CHUNK_W-1:0] cfg_wdata,
  input  logic               req_valid,
  output logic               req_stall,
  input  scba_req_t          req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output scba_rsp_t          rsp
);

  localparam int NUM_CLASSES = MAX_CLASS + 1;
  localparam int CI_W        = $clog2(NUM_CLASSES);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ST_DEPTH    = NUM_CLASSES * STACK_DEPTH;
  localparam int SA_W        = $clog2(ST_DEPTH);

  // Sequencer states. Free goes IDLE, FREE, DONE. Allocate goes IDLE, CLASS,
  // ALLOC and then either straight to DONE or through POP when a stacked
  // block is being read back.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FREE  = 3'd1;
  localparam logic [2:0] S_CLASS = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // First entry of a class's stack in the shared stack memory.
  function automatic logic [SA_W-1:0] stack_base(input logic [CI_W-1:0] c);
    stack_base = SA_W'(SA_W'(c) * SA_W'(STACK_DEPTH));
  endfunction

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [CHUNK_W-1:0]        chunk_bytes;
  logic [CHUNK_W-1:0]        chunk_base;
  logic [CHUNK_W-1:0]        bump_top;
  logic [CNT_W-1:0]          counts [NUM_CLASSES];
  logic [SIZE_W-1:0]         size_q;
  logic [HEAP_ADDR_BITS-1:0] faddr;
  logic [CLS_W-1:0]          cls;
  logic [AW-1:0]             fp;
  logic                      zero_q;
  logic                      large_q;
  scba_rsp_t                 pend;

  logic                      accept;
  logic                      take;

  // Class computation.
  logic [SIZE_W-1:0]         size_m1;
  logic [CLS_W-1:0]          cls_c;
  logic [AW-1:0]             fp_c;

  // Allocate decision.
  logic [CI_W-1:0]           cidx;
  logic [CNT_W-1:0]          cnt_a;
  logic [AW-1:0]             eff;
  logic [AW-1:0]             chunk_end;
  logic [AW-1:0]             limit;
  logic                      over;
  logic                      nomem;
  logic [AW-1:0]             top_sel;
  logic [AW-1:0]             user;
  logic [AW-1:0]             new_top;
  logic                      a_large;
  logic                      a_pop;
  logic                      a_bump;

  // Free decision.
  logic [CLS_W-1:0]          tag_rd;
  logic [CLS_W-1:0]          fcls;
  logic [CI_W-1:0]           fidx;
  logic [CNT_W-1:0]          cnt_f;
  logic                      full;

  // Memory ports.
  logic                      st_we;
  logic [SA_W-1:0]           st_waddr;
  logic                      st_re;
  logic [SA_W-1:0]           st_raddr;
  logic [HEAP_ADDR_BITS-1:0] st_rdata;
  logic                      tag_we;
  logic                      tag_re;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  // The response register can take a new word when it is empty or drained.
  assign take      = !rsp_valid || !rsp_stall;

  // Class of a size: the bit length of size minus one, so that 2^c is the
  // smallest power of two that holds the size. A zero size is caught by its
  // own flag.
  assign size_m1 = size_q - SIZE_W'(1);

  always_comb begin
    cls_c = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size_m1[i]) begin
        cls_c = CLS_W'(i + 1);
      end
    end
  end

  // Footprint: the header plus the block rounded up to sixteen bytes.
  assign fp_c = (cls_c < CLS_W'(4)) ? AW'(HDR16 + 16)
                                    : AW'(HDR16) + (AW'(1) << cls_c);

  // Allocate: pop when the class stack holds a block, otherwise carve from
  // the current chunk, moving to the next chunk when this one has no room.
  assign cidx      = cls[CI_W-1:0];
  assign cnt_a     = counts[cidx];
  assign eff       = AW'({chunk_bytes[CHUNK_W-1:4], 4'b0000});
  assign chunk_end = AW'(chunk_base) + eff;
  assign limit     = (chunk_end > HEAP_END) ? HEAP_END : chunk_end;
  assign over      = (AW'(bump_top) + fp) > limit;
  assign nomem     = over && ((chunk_end + fp) > HEAP_END);
  assign top_sel   = over ? chunk_end : AW'(bump_top);
  assign user      = top_sel + AW'(HDR16);
  assign new_top   = top_sel + fp;
  assign a_large   = large_q || (fp > eff);
  assign a_pop     = !zero_q && !a_large && (cnt_a != '0);
  assign a_bump    = !zero_q && !a_large && (cnt_a == '0) && !nomem;

  // Free: a tag above the largest class is folded onto the largest class.
  assign fcls  = (tag_rd > CLS_W'(MAX_CLASS)) ? CLS_W'(MAX_CLASS) : tag_rd;
  assign fidx  = fcls[CI_W-1:0];
  assign cnt_f = counts[fidx];
  assign full  = (cnt_f >= CNT_W'(STACK_DEPTH));

  assign st_we    = (state == S_FREE) && !full;
  assign st_waddr = stack_base(fidx) + SA_W'(cnt_f);
  assign st_re    = (state == S_ALLOC) && a_pop;
  assign st_raddr = stack_base(cidx) + SA_W'(cnt_a - CNT_W'(1));
  assign tag_re   = accept && (req.cmd == CMD_FREE);
  assign tag_we   = (state == S_ALLOC) && a_bump;

  // Stacked addresses of all classes, one region of STACK_DEPTH per class.
  scba_ram #(
    .DEPTH (ST_DEPTH),
    .WIDTH (HEAP_ADDR_BITS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (faddr),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Class tag of every block, indexed by user address over sixteen.
  scba_ram #(
    .DEPTH (TAG_DEPTH),
    .WIDTH (CLS_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (user[HEAP_ADDR_BITS-1:4]),
    .wdata (cls),
    .re    (tag_re),
    .raddr (req.free_addr[HEAP_ADDR_BITS-1:4]),
    .rdata (tag_rd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.cmd == CMD_FREE) ? S_FREE : S_CLASS;
        end
      end
      S_FREE:  state_next = S_DONE;
      S_CLASS: state_next = S_ALLOC;
      S_ALLOC: state_next = a_pop ? S_POP : S_DONE;
      S_POP:   state_next = S_DONE;
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The chunk size must be written only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= CHUNK_RESET;
    end else if (cfg_we) begin
      chunk_bytes <= cfg_wdata;
    end
  end

  // Request capture and class registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      size_q <= req.req_size;
      faddr  <= req.free_addr;
    end
    if (state == S_CLASS) begin
      cls     <= cls_c;
      fp      <= fp_c;
      zero_q  <= (size_q == '0);
      large_q <= (cls_c > CLS_W'(MAX_CLASS)) || (cls_c > CLS_W'(CLASS_EXP_LIMIT));
    end
  end

  // Stack fill counts and chunk pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts[i] <= '0;
      end
      chunk_base <= '0;
      bump_top   <= '0;
    end else begin
      if (st_we) begin
        counts[fidx] <= cnt_f + CNT_W'(1);
      end
      if (st_re) begin
        counts[cidx] <= cnt_a - CNT_W'(1);
      end
      if (tag_we) begin
        bump_top <= new_top[CHUNK_W-1:0];
        if (over) begin
          chunk_base <= chunk_end[CHUNK_W-1:0];
        end
      end
    end
  end

  // Pending response, built while the item is worked on.
  always_ff @(posedge clk) begin
    unique case (state)
      S_FREE: begin
        pend.addr   <= '0;
        pend.status <= full ? ST_FULL : ST_OK;
      end
      S_ALLOC: begin
        if (zero_q) begin
          pend.addr   <= '0;
          pend.status <= ST_ZERO;
        end else if (a_large) begin
          pend.addr   <= '0;
          pend.status <= ST_LARGE;
        end else if (a_pop) begin
          pend.addr   <= '0;
          pend.status <= ST_OK;
        end else if (nomem) begin
          pend.addr   <= '0;
          pend.status <= ST_NOMEM;
        end else begin
          pend.addr   <= user[HEAP_ADDR_BITS-1:0];
          pend.status <= ST_OK;
        end
      end
      S_POP: begin
        pend.addr   <= st_rdata;
        pend.status <= ST_OK;
      end
      default: begin
        pend <= pend;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && take) begin
      rsp <= pend;
    end
  end

endmodule

@@ rtl/scba_checker.sv @@
// ----------------------------------------------------------------------------
// scba_checker: port-level checks of the size class block allocator
// Watches the request and response channels of the top level and is
// attached to it by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module scba_checker import scba_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input scba_rsp_t rsp
);

  // A stalled response word stays valid and unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed or was dropped");

  // Every failed request and every free reports a zero address, so a
  // non-zero status never comes with an address.
  a_err_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.addr == '0))
    else $error("error response carries an address");

  // The block works on one request at a time: it is busy right after one
  // is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while the previous one is in flight");

  // Reset empties the response register.
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

@@ tb/size_class_block_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// size_class_block_allocator_tb: self-checking bench for the block allocator
// Drives allocate and free words through the request channel under random
// idling on both sides. It keeps its own copy of the free stacks, the chunk
// pointers and the class tags, works out the response word of every accepted
// request, and checks each response field by field, in order.
// ----------------------------------------------------------------------------
module size_class_block_allocator_tb import scba_pkg::*;;

  localparam int unsigned HEAP_BYTES = 1 << HEAP_ADDR_BITS;
  localparam int unsigned NUM_CLASSES = MAX_CLASS_DEF + 1;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_we      = 1'b0;
  logic [CHUNK_W-1:0] cfg_wdata   = '0;
  logic               req_valid   = 1'b0;
  logic               req_stall;
  scba_req_t          req         = '0;
  logic               rsp_valid;
  logic               rsp_stall   = 1'b0;
  scba_rsp_t          rsp;

  // Idling rates, in percent per cycle, for the sender and the receiver.
  int unsigned send_idle_pct  = 21;
  int unsigned recv_stall_pct = 60;
  int unsigned fail_count     = 0;

  // Response words still owed by the block, oldest first.
  scba_rsp_t awaited_rsps[$];
  scba_rsp_t last_rsp;
  scba_rsp_t head_rsp;

  // The bench's own view of the allocator state. The tag store is sparse:
  // only entries written by an allocation exist.
  logic [CHUNK_W-1:0]        chunk_cfg;
  int unsigned               heap_chunk_base;
  int unsigned               heap_bump;
  logic [HEAP_ADDR_BITS-1:0] free_list_mem [NUM_CLASSES][STACK_DEPTH_DEF];
  int unsigned               free_list_fill [NUM_CLASSES];
  logic [CLS_W-1:0]          class_of_block [int unsigned];

  // Addresses handed out and not yet freed by the random traffic, and every
  // address ever handed out (used for double and offset frees).
  logic [HEAP_ADDR_BITS-1:0] live_blocks[$];
  logic [HEAP_ADDR_BITS-1:0] seen_blocks[$];

  size_class_block_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver stalls at random; one nonblocking update per edge.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Works out the response word of one request and updates the bench's copy
  // of the allocator state, exactly as the block should at acceptance.
  function automatic scba_rsp_t allocator_response(input scba_req_t w);
    scba_rsp_t   r;
    int unsigned span;
    int unsigned cls;
    int unsigned foot;
    int unsigned limit;
    int unsigned next_base;
    int unsigned user;
    r.addr   = '0;
    r.status = ST_OK;
    // Chunks are carved in whole 16-byte units.
    span = int'(chunk_cfg) & ~32'd15;
    if (w.cmd == CMD_ALLOC) begin
      if (w.req_size == '0) begin
        r.status = ST_ZERO;
      end else begin
        cls = 0;
        while (cls < 31 && (32'd1 << cls) < w.req_size) cls++;
        foot = HDR16 + (((32'd1 << cls) + 15) & ~32'd15);
        if (cls > MAX_CLASS_DEF || cls > CLASS_EXP_LIMIT || foot > span) begin
          r.status = ST_LARGE;
        end else if (free_list_fill[cls] != 0) begin
          // A freed block of this class is reused, last in first out.
          free_list_fill[cls]--;
          r.addr = free_list_mem[cls][free_list_fill[cls]];
        end else begin
          limit = heap_chunk_base + span;
          if (limit > HEAP_BYTES) limit = HEAP_BYTES;
          if (heap_bump + foot > limit) begin
            // Abandon what is left of this chunk and open the next one.
            next_base = heap_chunk_base + span;
            if (next_base + foot > HEAP_BYTES) begin
              r.status = ST_NOMEM;
            end else begin
              heap_chunk_base = next_base;
              heap_bump       = next_base;
            end
          end
          if (r.status == ST_OK) begin
            user = heap_bump + HDR16;
            class_of_block[(user >> 4) & (TAG_DEPTH - 1)] = CLS_W'(cls);
            heap_bump += foot;
            r.addr = HEAP_ADDR_BITS'(user);
          end
        end
      end
    end else begin
      // No check of the address: the tag of its 16-byte slot decides.
      cls = class_of_block[w.free_addr[HEAP_ADDR_BITS-1:4]];
      if (cls > MAX_CLASS_DEF) cls = MAX_CLASS_DEF;
      if (free_list_fill[cls] >= STACK_DEPTH_DEF) begin
        r.status = ST_FULL;
      end else begin
        free_list_mem[cls][free_list_fill[cls]] = w.free_addr;
        free_list_fill[cls]++;
      end
    end
    return r;
  endfunction

  // The field that a command ignores carries random bits.
  function automatic scba_req_t alloc_word(input logic [SIZE_W-1:0] size);
    scba_req_t w;
    w.cmd       = CMD_ALLOC;
    w.req_size  = size;
    w.free_addr = HEAP_ADDR_BITS'($urandom);
    return w;
  endfunction

  function automatic scba_req_t free_word(input logic [HEAP_ADDR_BITS-1:0] a);
    scba_req_t w;
    w.cmd       = CMD_FREE;
    w.req_size  = SIZE_W'($urandom);
    w.free_addr = a;
    return w;
  endfunction

  // Mostly small blocks, some middling ones and only a few of the largest,
  // so that the heap lasts through the random traffic.
  function automatic logic [SIZE_W-1:0] random_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 3)  return '0;
    if (p < 63) return SIZE_W'($urandom_range(1, 64));
    if (p < 93) return SIZE_W'($urandom_range(65, 2048));
    return SIZE_W'($urandom_range(2049, 65536));
  endfunction

  // Presents one request word and holds it until it is taken. Valid stays
  // high afterwards unless the sender decides to idle, so back-to-back words
  // never see valid lowered and raised within one time step.
  task automatic send_word(input scba_req_t w);
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    last_rsp = allocator_response(w);
    awaited_rsps.push_back(last_rsp);
    if (w.cmd == CMD_ALLOC && last_rsp.status == ST_OK) begin
      live_blocks.push_back(last_rsp.addr);
      seen_blocks.push_back(last_rsp.addr);
    end
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Waits until every owed response has come back, then lets the deepest
  // pipeline path empty out before anything else happens.
  task automatic drain();
    req_valid <= 1'b0;
    while (awaited_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_chunk_bytes(input logic [CHUNK_W-1:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    chunk_cfg = v;
    @(posedge clk);
  endtask

  // Default chunk size straight out of reset: refusals, carving and the
  // opening of a second chunk once the first has no room.
  task automatic test_alloc_paths();
    send_word(alloc_word('0));
    send_word(alloc_word(SIZE_W'(1)));
    send_word(alloc_word(SIZE_W'(16)));
    send_word(alloc_word(SIZE_W'(17)));
    send_word(alloc_word(SIZE_W'(2048)));
    send_word(alloc_word(SIZE_W'(2048)));
    send_word(alloc_word(SIZE_W'(4080)));
    send_word(alloc_word(SIZE_W'(65536)));
  endtask

  // Freed blocks come back last in first out; an offset or repeated free
  // is pushed exactly as given.
  task automatic test_free_reuse();
    logic [HEAP_ADDR_BITS-1:0] tiny_blk;
    logic [HEAP_ADDR_BITS-1:0] mid_blk;
    send_word(alloc_word(SIZE_W'(1)));
    tiny_blk = last_rsp.addr;
    send_word(alloc_word(SIZE_W'(24)));
    mid_blk = last_rsp.addr;
    send_word(free_word(tiny_blk));
    send_word(alloc_word(SIZE_W'(1)));
    send_word(free_word(mid_blk | HEAP_ADDR_BITS'(7)));
    send_word(alloc_word(SIZE_W'(20)));
    send_word(free_word(tiny_blk));
    send_word(free_word(tiny_blk));
    send_word(alloc_word(SIZE_W'(1)));
    send_word(alloc_word(SIZE_W'(1)));
  endtask

  // The smallest chunk holds exactly one 16-byte block with its header; an
  // unaligned setting is rounded down; a heap-sized one takes the biggest block.
  task automatic test_chunk_extremes();
    write_chunk_bytes(CHUNK_W'(32));
    send_word(alloc_word(SIZE_W'(16)));
    send_word(alloc_word(SIZE_W'(1)));
    send_word(alloc_word(SIZE_W'(17)));
    write_chunk_bytes(CHUNK_W'(47));
    send_word(alloc_word(SIZE_W'(9)));
    send_word(alloc_word(SIZE_W'(20)));
    write_chunk_bytes(CHUNK_W'(1048576));
    send_word(alloc_word(SIZE_W'(65536)));
  endtask

  // One more push than the stack holds: the last one must be dropped.
  task automatic test_stack_full();
    logic [HEAP_ADDR_BITS-1:0] blk;
    write_chunk_bytes(CHUNK_W'(4096));
    send_word(alloc_word(SIZE_W'(8)));
    blk = last_rsp.addr;
    repeat (STACK_DEPTH_DEF + 1) send_word(free_word(blk));
    repeat (2) send_word(alloc_word(SIZE_W'(8)));
  endtask

  // Random traffic: mostly allocations and frees of blocks still held, with
  // a share of repeated and offset frees of earlier blocks as noise.
  task automatic run_random(input logic [CHUNK_W-1:0] chunk, input int unsigned count);
    scba_req_t   w;
    int unsigned pick;
    int unsigned idx;
    write_chunk_bytes(chunk);
    repeat (count) begin
      w    = alloc_word(random_size());
      pick = $urandom_range(99);
      if (pick < 40 && live_blocks.size() != 0) begin
        idx = $urandom_range(live_blocks.size() - 1);
        w   = free_word(live_blocks[idx]);
        live_blocks.delete(idx);
      end else if (pick < 46 && seen_blocks.size() != 0) begin
        idx = $urandom_range(seen_blocks.size() - 1);
        w   = free_word(seen_blocks[idx] | HEAP_ADDR_BITS'($urandom_range(15)));
      end
      send_word(w);
    end
  endtask

  // Largest blocks until the heap is used up, then hand them all back and
  // take some again from the free stack.
  task automatic test_out_of_memory();
    logic [HEAP_ADDR_BITS-1:0] big_blocks[$];
    int unsigned               tries;
    write_chunk_bytes(CHUNK_W'(1048576));
    tries = 0;
    do begin
      send_word(alloc_word(SIZE_W'(65536)));
      if (last_rsp.status == ST_OK) big_blocks.push_back(last_rsp.addr);
      tries++;
    end while (last_rsp.status == ST_OK && tries < 100);
    foreach (big_blocks[i]) send_word(free_word(big_blocks[i]));
    repeat (2) send_word(alloc_word(SIZE_W'(65536)));
    send_word(alloc_word(SIZE_W'(1)));
  endtask

  // Every response word taken is compared with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsps.size() == 0) begin
        $error("response word with none outstanding: addr %0h status %0d",
               rsp.addr, rsp.status);
        fail_count++;
      end else begin
        head_rsp = awaited_rsps.pop_front();
        if (rsp.addr !== head_rsp.addr) begin
          $error("addr: expected %0h, got %0h", head_rsp.addr, rsp.addr);
          fail_count++;
        end
        if (rsp.status !== head_rsp.status) begin
          $error("status: expected %0d, got %0d", head_rsp.status, rsp.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    chunk_cfg       = CHUNK_RESET;
    heap_chunk_base = 0;
    heap_bump       = 0;
    foreach (free_list_fill[i]) free_list_fill[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_alloc_paths();
    test_free_reuse();
    test_chunk_extremes();
    test_stack_full();

    run_random(CHUNK_W'(4096), 220);
    drain();
    send_idle_pct  = 60;
    recv_stall_pct = 21;
    run_random(CHUNK_W'(1048575), 220);
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(CHUNK_W'(1000), 220);

    test_out_of_memory();
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // A hang anywhere ends the run as a failure.
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
